FILE: rtl/status_frame_receiver_assert.svh
// Assertion macros for the status frame receiver.
// Used by the top level; needs no other file.
`ifndef STATUS_FRAME_RECEIVER_ASSERT_SVH
`define STATUS_FRAME_RECEIVER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("status_frame_receiver: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("status_frame_receiver: next-cycle check failed");

`endif

FILE: rtl/sfr_pkg.sv
// Package for the status frame receiver: codes, reset values, types, CRC step.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int unsigned FRAME_BYTES_DEF = 20;
    localparam int unsigned HDR_BYTES       = 12;
    localparam int unsigned HDR_IDX_W       = $clog2(HDR_BYTES);

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [3:0]  COUNT_MAX = 4'd15;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FUNC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_FROM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN    = 2'd3;

    localparam logic [7:0]  START_FUNC_RST = 8'h05;
    localparam logic [15:0] SPEED_LIM_RST  = 16'h003E;
    localparam logic [3:0]  CLASS_FROM_RST = 4'd3;
    localparam logic [3:0]  SEQ_LEN_RST    = 4'd9;

    typedef enum logic [2:0] {
        ST_START_ECHO  = 3'd0,
        ST_CRC_ERROR   = 3'd1,
        ST_TOO_EARLY   = 3'd2,
        ST_STOPPED     = 3'd3,
        ST_OBSTRUCTED  = 3'd4,
        ST_NORMAL      = 3'd5,
        ST_UNCLASSIFIED = 3'd6
    } t_frame_status;

    // Control for the running CRC register
    typedef struct packed {
        logic upd;
        logic clr;
    } t_crc_ctl;

    // Register words and obstruction byte of a finished frame
    typedef struct packed {
        logic [15:0] w2;
        logic [15:0] w3;
        logic [15:0] w4;
        logic [7:0]  b11;
    } t_cls_in;

    // One byte of CRC-16/Modbus, eight reflected shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/sfr_byte_if.sv
// Valid/ready channel carrying one received byte.
// No dependencies.
`timescale 1ns / 1ps

interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/sfr_result_if.sv
// Valid/ready channel carrying one frame result.
// No dependencies.
`timescale 1ns / 1ps

interface sfr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] device_address;
    logic [7:0] function_code;
    logic [2:0] frame_status;
    logic       crc_ok;
    logic [3:0] message_index;
    logic       in_sequence;

    modport source (output valid, output device_address, output function_code,
                    output frame_status, output crc_ok, output message_index,
                    output in_sequence, input ready);
    modport sink   (input valid, input device_address, input function_code,
                    input frame_status, input crc_ok, input message_index,
                    input in_sequence, output ready);
endinterface

FILE: rtl/sfr_crc_unit.sv
// Running CRC-16/Modbus register, one byte per cycle.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_crc_unit
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_crc_ctl   i_ctl,
    input  logic [7:0] i_byte,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // Restart at frame end, fold in covered bytes
    always_comb begin
        n_crc = r_crc;
        if (i_ctl.clr) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.upd) begin
            n_crc = crc16_byte(r_crc, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

FILE: rtl/sfr_classify.sv
// Classification of a good frame from its register words and byte 11.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_classify
    import sfr_pkg::*;
(
    input  t_cls_in       i_cls,
    input  logic [15:0]   i_speed_limit,
    output t_frame_status o_status
);

    // Stopped beats obstructed beats normal
    always_comb begin
        if (i_cls.w2 == 16'd0 && i_cls.w3 == 16'd0 && i_cls.w4 == 16'd0) begin
            o_status = ST_STOPPED;
        end else if (i_cls.b11 != 8'd0) begin
            o_status = ST_OBSTRUCTED;
        end else if (i_cls.w2 != 16'd0 && i_cls.w3 <= i_speed_limit) begin
            o_status = ST_NORMAL;
        end else begin
            o_status = ST_UNCLASSIFIED;
        end
    end

endmodule

FILE: rtl/status_frame_receiver.sv
// Status frame receiver top level: input register, frame state, result register.
// Depends on sfr_pkg, sfr_byte_if, sfr_result_if, sfr_crc_unit, sfr_classify
// and status_frame_receiver_assert.svh.
//
// Usage:
//   i_rx carries received bytes, one per item; frames are FRAME_BYTES long.
//   o_res gives one item per completed frame: address, function code, status,
//   CRC match, sequence index and sequence flag. Other bytes give no item.
//   Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
//   while the block is idle.
// Timing:
//   A byte waits in the input register and is processed as it leaves; the
//   result of a frame's last byte is loaded into the result register as that
//   byte leaves the input register and is held there until taken. One byte per
//   cycle is sustained while results are taken; the CRC step for a byte is an
//   unrolled 8-bit update between the input register and the CRC register.
// Reset (synchronous, active low) clears the frame position, CRC, sequence
//   state and configuration to defaults; no clearing pass is needed.
// Stall: while a result waits on o_res.ready, the byte in the input register
//   holds and i_rx.ready drops once that register is full.
`timescale 1ns / 1ps

`include "status_frame_receiver_assert.svh"

module status_frame_receiver
    import sfr_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfr_byte_if.sink              i_rx,
    sfr_result_if.source          o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CRC_LO_POS = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] HDR_END    = POS_W'(HDR_BYTES);

    // Configuration registers
    logic [7:0]  r_start_func;
    logic [15:0] r_speed_lim;
    logic [3:0]  r_class_from;
    logic [3:0]  r_seq_len;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Frame and sequence state
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_hdr [HDR_BYTES];
    logic [7:0]       r_crc_lo;
    logic [3:0]       r_seq_cnt;
    logic [3:0]       n_seq_cnt;
    logic [7:0]       r_prev_func;
    logic             r_seq_flag;
    logic             n_seq_flag;

    // Result register
    logic          r_out_valid;
    logic [7:0]    r_out_addr;
    logic [7:0]    r_out_func;
    t_frame_status r_out_status;
    t_frame_status n_status;
    logic          r_out_ok;
    logic [3:0]    r_out_idx;
    logic [3:0]    n_idx;
    logic          r_out_flag;

    logic          w_adv;
    logic          w_proc;
    logic          w_last;
    logic          w_ok;
    logic [3:0]    w_cnt_adv;
    logic [15:0]   w_crc;
    t_crc_ctl      w_crc_ctl;
    t_cls_in       w_cls;
    t_frame_status w_cls_status;

    // Handshake: result register frees space, input register follows
    assign w_adv      = !r_out_valid || o_res.ready;
    assign w_proc     = r_in_valid && w_adv;
    assign w_last     = (r_pos == LAST_POS);
    assign i_rx.ready = !r_in_valid || w_adv;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_func <= START_FUNC_RST;
            r_speed_lim  <= SPEED_LIM_RST;
            r_class_from <= CLASS_FROM_RST;
            r_seq_len    <= SEQ_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_FUNC: r_start_func <= i_cfg_data[7:0];
                CFG_SPEED_LIM:  r_speed_lim  <= i_cfg_data;
                CFG_CLASS_FROM: r_class_from <= i_cfg_data[3:0];
                CFG_SEQ_LEN:    r_seq_len    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Advance the byte position, wrap at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_proc) begin
            r_pos <= w_last ? '0 : r_pos + 1'b1;
        end
    end

    // Keep the header bytes and the low CRC byte
    always_ff @(posedge i_clk) begin
        if (w_proc && r_pos < HDR_END) begin
            r_hdr[r_pos[HDR_IDX_W-1:0]] <= r_in_byte;
        end
        if (w_proc && r_pos == CRC_LO_POS) begin
            r_crc_lo <= r_in_byte;
        end
    end

    // Running CRC over all bytes but the last two
    assign w_crc_ctl.upd = w_proc && (r_pos < CRC_LO_POS);
    assign w_crc_ctl.clr = w_proc && w_last;

    sfr_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .i_byte  (r_in_byte),
        .o_crc   (w_crc)
    );

    // Classification of the frame in the store
    assign w_cls.w2  = {r_hdr[5], r_hdr[6]};
    assign w_cls.w3  = {r_hdr[7], r_hdr[8]};
    assign w_cls.w4  = {r_hdr[9], r_hdr[10]};
    assign w_cls.b11 = r_hdr[11];

    sfr_classify u_cls (
        .i_cls         (w_cls),
        .i_speed_limit (r_speed_lim),
        .o_status      (w_cls_status)
    );

    // Frame end: CRC check and sequence counter update
    assign w_ok = ({r_in_byte, r_crc_lo} == w_crc);

    always_comb begin
        if (r_prev_func == r_start_func) begin
            w_cnt_adv = 4'd1;
        end else if (r_seq_cnt < COUNT_MAX) begin
            w_cnt_adv = r_seq_cnt + 4'd1;
        end else begin
            w_cnt_adv = r_seq_cnt;
        end
    end

    always_comb begin
        n_seq_cnt  = w_cnt_adv;
        n_seq_flag = r_seq_flag;
        n_idx      = w_cnt_adv;
        n_status   = ST_CRC_ERROR;
        if (r_hdr[1] == r_start_func) begin
            n_seq_cnt  = 4'd1;
            n_seq_flag = 1'b1;
            n_idx      = 4'd1;
            n_status   = ST_START_ECHO;
        end else if (w_ok) begin
            n_status = (w_cnt_adv >= r_class_from) ? w_cls_status : ST_TOO_EARLY;
            if (w_cnt_adv >= r_seq_len) begin
                n_seq_cnt  = 4'd0;
                n_seq_flag = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_cnt   <= 4'd0;
            r_seq_flag  <= 1'b0;
            r_prev_func <= 8'd0;
        end else if (w_proc && w_last) begin
            r_seq_cnt   <= n_seq_cnt;
            r_seq_flag  <= n_seq_flag;
            r_prev_func <= r_hdr[1];
        end
    end

    // Result register: load on frame end, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_proc && w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_last) begin
            r_out_addr   <= r_hdr[0];
            r_out_func   <= r_hdr[1];
            r_out_status <= n_status;
            r_out_ok     <= w_ok;
            r_out_idx    <= n_idx;
            r_out_flag   <= n_seq_flag;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.device_address = r_out_addr;
    assign o_res.function_code  = r_out_func;
    assign o_res.frame_status   = 3'(r_out_status);
    assign o_res.crc_ok         = r_out_ok;
    assign o_res.message_index  = r_out_idx;
    assign o_res.in_sequence    = r_out_flag;

    // Checks
    `SFR_ASSERT_NEXT(a_frame_end_result, i_clk, i_rst_n, w_proc && w_last, r_out_valid)
    `SFR_ASSERT_NOW(a_pos_in_frame, i_clk, i_rst_n, 1'b1, r_pos <= LAST_POS)
    `SFR_ASSERT_NOW(a_flag_needs_count, i_clk, i_rst_n, r_seq_flag, r_seq_cnt != 4'd0)
    `SFR_ASSERT_NOW(a_echo_result, i_clk, i_rst_n,
        r_out_valid && r_out_status == ST_START_ECHO, r_out_flag && r_out_idx == 4'd1)

endmodule
